[rtl/ggb_pkg.sv]
// Package for the glyph grid binarizer: controller/datapath command and status types.
// No dependencies.
package ggb_pkg;
  localparam int GRID = 16;
  localparam int GRID_W = 4;

  typedef struct packed {
    logic load;       // store one pixel and update the box
    logic fit_start;  // latch box, start span fitting
    logic fit_step;   // one widening step on both axes
    logic vote_clr;   // clear tallies, start a cell sweep
    logic vote_step;  // visit one pixel of the current cell
    logic cell_done;  // fold the cell vote into the row word
    logic row_emit;   // emit the row word
    logic frame_clr;  // return frame state to reset values
  } ggb_cmd_t;

  typedef struct packed {
    logic fit_done;
    logic cell_end;   // last pixel of the cell is being visited
    logic cell_skip;  // cell gives zero without a sweep
    logic col_last;   // current cell is the last of the row
    logic row_last;   // current row is the last of the grid
  } ggb_sts_t;
endpackage

[rtl/ggb_datapath.sv]
// Datapath of the glyph grid binarizer: light map memory, box tracking, span fit, cell vote.
// Depends on ggb_pkg.
module ggb_datapath #(
  parameter int MAX_WIDTH = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [8:0]      image_width,
  input  logic [8:0]      image_height,
  input  logic [7:0]      red,
  input  logic [7:0]      green,
  input  logic [7:0]      blue,
  input  ggb_pkg::ggb_cmd_t cmd,
  output ggb_pkg::ggb_sts_t sts,
  output logic [15:0]     row_bits,
  output logic [3:0]      row_number,
  output logic            last_row
);
  import ggb_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int EW = 12;           // signed edge width, room for widening below zero
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW = XW + YW;

  logic light_map [DEPTH];

  // effective sizes
  logic [EW-1:0] w_eff, h_eff;
  always_comb begin
    if (image_width == 9'd0) w_eff = EW'(1);
    else if (32'(image_width) > MAX_WIDTH) w_eff = EW'(MAX_WIDTH);
    else w_eff = EW'(image_width);
    if (image_height == 9'd0) h_eff = EW'(1);
    else if (32'(image_height) > MAX_HEIGHT) h_eff = EW'(MAX_HEIGHT);
    else h_eff = EW'(image_height);
  end

  logic signed [EW-1:0] left_edge, right_edge, top_edge, bottom_edge;
  logic [EW-1:0] load_column, load_row;

  logic is_light, is_dark;
  assign is_light = red[7] & green[7] & blue[7];
  assign is_dark = ~red[7] & ~green[7] & ~blue[7];

  // load position after a wrap left from the previous pixel
  logic [EW-1:0] lc, lr;
  logic in_img;
  always_comb begin
    lc = load_column;
    lr = load_row;
    if (lc >= w_eff) begin
      lc = '0;
      if (lr < h_eff) lr = lr + 1'b1;
    end
    in_img = lr < h_eff;
  end

  // fitting state
  logic signed [EW-1:0] lx, hx, ly, hy;
  logic [5:0] fit_i;
  logic any;
  logic x_ok, y_ok;
  assign x_ok = (hx - lx) % GRID == 0;
  assign y_ok = (hy - ly) % GRID == 0;

  logic signed [EW-1:0] cw, ch;
  assign cw = (hx - lx) >>> GRID_W;
  assign ch = (hy - ly) >>> GRID_W;

  // sweep state
  logic [GRID_W-1:0] gr, gc;
  logic signed [EW-1:0] cx, cy, p, q;
  logic [17:0] dark_tally, light_tally;
  logic rd_pend, rd_bit;
  logic [15:0] bits;

  logic signed [EW-1:0] px, py;
  logic pin;
  assign px = cx + q;
  assign py = cy + p;
  assign pin = (px >= 0) && (py >= 0) && (px < $signed(w_eff)) && (py < $signed(h_eff));
  assign sts.cell_skip = !any || cx < 0 || cy < 0 || cx >= $signed(w_eff) || cy >= $signed(h_eff)
                         || cw == 0 || ch == 0;
  assign sts.cell_end = (q == cw - 1) && (p == ch - 1);
  assign sts.col_last = gc == GRID_W'(GRID - 1);
  assign sts.row_last = gr == GRID_W'(GRID - 1);
  assign sts.fit_done = (x_ok && y_ok) || fit_i == 6'(2 * GRID);

  logic [AW-1:0] waddr, raddr;
  assign waddr = {lr[YW-1:0], lc[XW-1:0]};
  assign raddr = {py[YW-1:0], px[XW-1:0]};

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (cmd.load && in_img) light_map[waddr] <= is_light;
    rd_bit <= light_map[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.frame_clr) begin
      left_edge <= $signed(w_eff);
      right_edge <= '0;
      top_edge <= $signed(h_eff);
      bottom_edge <= '0;
      load_column <= '0;
      load_row <= '0;
      rd_pend <= 1'b0;
    end else begin
      // store pixel, track box
      if (cmd.load) begin
        if (in_img) begin
          if (lc + 1'b1 >= w_eff) begin
            load_column <= '0;
            load_row <= lr + 1'b1;
          end else begin
            load_column <= lc + 1'b1;
            load_row <= lr;
          end
          if (is_dark) begin
            if ($signed(lc) < left_edge) left_edge <= $signed(lc);
            if ($signed(lc) > right_edge) right_edge <= $signed(lc);
            if ($signed(lr) < top_edge) top_edge <= $signed(lr);
            if ($signed(lr) > bottom_edge) bottom_edge <= $signed(lr);
          end
        end else begin
          load_column <= lc;
          load_row <= lr;
        end
      end
      rd_pend <= cmd.vote_step && pin;
    end
    // fit: round up to even, then widen alternately
    if (cmd.fit_start) begin
      lx <= left_edge + EW'(left_edge[0]);
      hx <= right_edge + EW'(right_edge[0]);
      ly <= top_edge + EW'(top_edge[0]);
      hy <= bottom_edge + EW'(bottom_edge[0]);
      any <= left_edge <= right_edge && top_edge <= bottom_edge;
      fit_i <= '0;
      gr <= '0;
      gc <= '0;
      bits <= '0;
    end
    if (cmd.fit_step) begin
      fit_i <= fit_i + 1'b1;
      if (!x_ok) begin
        if (fit_i[0]) hx <= hx + EW'(2);
        else lx <= lx - EW'(2);
      end
      if (!y_ok) begin
        if (fit_i[0]) hy <= hy + EW'(2);
        else ly <= ly - EW'(2);
      end
    end
    // cell sweep
    if (cmd.vote_clr) begin
      cx <= lx + $signed(EW'(gc)) * cw;
      cy <= ly + $signed(EW'(gr)) * ch;
      p <= '0;
      q <= '0;
      dark_tally <= '0;
      light_tally <= '0;
    end
    if (cmd.vote_step) begin
      if (q == cw - 1) begin
        q <= '0;
        p <= p + 1'b1;
      end else begin
        q <= q + 1'b1;
      end
    end
    // count the bit read on the previous cycle
    if (rd_pend) begin
      if (rd_bit) light_tally <= light_tally + 1'b1;
      else dark_tally <= dark_tally + 1'b1;
    end
    if (cmd.cell_done) begin
      bits[GRID - 1 - gc] <= !sts.cell_skip && dark_tally > light_tally;
      gc <= gc + 1'b1;
    end
    if (cmd.row_emit) begin
      bits <= '0;
      gr <= gr + 1'b1;
    end
  end

  assign row_bits = bits;
  assign row_number = gr;
  assign last_row = sts.row_last;
endmodule

[rtl/ggb_ctrl.sv]
// Controller of the glyph grid binarizer: sequences load, fit, per-cell sweep and row output.
// Depends on ggb_pkg.
module ggb_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            frame_end,
  input  ggb_pkg::ggb_sts_t sts,
  output ggb_pkg::ggb_cmd_t cmd,
  output logic            busy,
  output logic            row_valid
);
  import ggb_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FIT0 = 3'd1;
  localparam logic [2:0] S_FIT = 3'd2;
  localparam logic [2:0] S_CELL = 3'd3;
  localparam logic [2:0] S_SWEEP = 3'd4;
  localparam logic [2:0] S_DRAIN = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;
  localparam logic [2:0] S_EMIT = 3'd7;

  logic [2:0] state, state_next;
  logic [1:0] drain, drain_next;

  assign busy = state != S_IDLE;
  assign row_valid = state == S_EMIT;

  always_comb begin
    state_next = state;
    drain_next = drain;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (frame_end) state_next = S_FIT0;
        end
      end
      S_FIT0: begin
        cmd.fit_start = 1'b1;
        state_next = S_FIT;
      end
      S_FIT: begin
        if (sts.fit_done) state_next = S_CELL;
        else cmd.fit_step = 1'b1;
      end
      S_CELL: begin
        cmd.vote_clr = 1'b1;
        state_next = S_SWEEP;
      end
      S_SWEEP: begin
        if (sts.cell_skip) state_next = S_DONE;
        else begin
          cmd.vote_step = 1'b1;
          if (sts.cell_end) begin
            state_next = S_DRAIN;
            drain_next = 2'd2;
          end
        end
      end
      S_DRAIN: begin
        drain_next = drain - 1'b1;
        if (drain == 2'd0) state_next = S_DONE;
      end
      S_DONE: begin
        cmd.cell_done = 1'b1;
        state_next = sts.col_last ? S_EMIT : S_CELL;
      end
      S_EMIT: begin
        cmd.row_emit = 1'b1;
        if (sts.row_last) begin
          cmd.frame_clr = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_CELL;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      drain <= '0;
    end else begin
      state <= state_next;
      drain <= drain_next;
    end
  end
endmodule

[rtl/glyph_grid_binarizer_core.sv]
// Top level of the glyph grid binarizer: config registers, controller and datapath.
// A non-final pixel is stored while idle; a final pixel adds a span fit and a sweep of 256
// cells: a skipped cell passes through setup, skip check and fold, any other cell visits one
// stored pixel per cycle between setup, a drain for the registered light map read and fold.
// Each of the 16 rows shows for one cycle with row_valid after its cells. No pixel is taken
// while busy. rst is synchronous; the light map is not cleared by reset.
module glyph_grid_binarizer_core #(
  parameter int MAX_WIDTH = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic        frame_end,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [8:0]  cfg_data,
  output logic        row_valid,
  output logic [15:0] row_bits,
  output logic [3:0]  row_number,
  output logic        last_row
);
  import ggb_pkg::*;

  localparam logic REG_WIDTH = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  logic [8:0] image_width, image_height;
  ggb_cmd_t cmd;
  ggb_sts_t sts;

  // hold configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= 9'd256;
      image_height <= 9'd256;
    end else if (cfg_we) begin
      if (cfg_index == REG_WIDTH) image_width <= cfg_data;
      if (cfg_index == REG_HEIGHT) image_height <= cfg_data;
    end
  end

  ggb_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .frame_end(frame_end),
    .sts(sts), .cmd(cmd), .busy(busy), .row_valid(row_valid)
  );

  ggb_datapath #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
    .clk(clk), .rst(rst), .image_width(image_width), .image_height(image_height),
    .red(red), .green(green), .blue(blue), .cmd(cmd), .sts(sts),
    .row_bits(row_bits), .row_number(row_number), .last_row(last_row)
  );
endmodule

[rtl/ggb_checker.sv]
// Port-level checks for the glyph grid binarizer core, bound to the top level.
// Depends only on the top level's ports.
module ggb_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        frame_end,
  input logic        row_valid,
  input logic [3:0]  row_number,
  input logic        last_row
);
  // a final pixel makes the block busy
  a_end_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && frame_end |=> busy) else $error("no busy after frame end");
  // last_row marks row 15 only
  a_last: assert property (@(posedge clk) disable iff (rst)
    row_valid |-> (last_row == (row_number == 4'd15))) else $error("last_row mismatch");
  // rows are never back to back
  a_gap: assert property (@(posedge clk) disable iff (rst)
    row_valid |=> !row_valid) else $error("rows adjacent");
  // after the last row the block goes idle
  a_idle: assert property (@(posedge clk) disable iff (rst)
    row_valid && last_row |=> !busy) else $error("busy after last row");
endmodule

bind glyph_grid_binarizer_core ggb_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .frame_end(frame_end),
  .row_valid(row_valid), .row_number(row_number), .last_row(last_row)
);
